>>> rtl/core/cbs_pkg.sv
package cbs_pkg;

	localparam int MAX_CELLS      = 5;
	localparam int CELL_COUNT_DEF = 3;
	localparam int CELL_MV_W      = 16;
	localparam int UNBAL_W        = 8;
	localparam int TEMP_W         = 8;
	localparam int SLOT_W         = 3;
	localparam int TEMP_BASE_C    = 30;
	localparam int TEMP_STEP_C    = 10;

	// stream payload layout
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 8;
	localparam int TEMP_LSB    = MAX_CELLS * CELL_MV_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERVOLTAGE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_START      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_LOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_HIGH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNBALANCE      = 3'd5;

	localparam logic [CELL_MV_W-1:0] OVERVOLTAGE_RST = 16'd4200;
	localparam logic [CELL_MV_W-1:0] MIN_START_RST   = 16'd4200;
	localparam logic [CELL_MV_W-1:0] VALID_LOW_RST   = 16'd2500;
	localparam logic [CELL_MV_W-1:0] VALID_HIGH_RST  = 16'd4500;
	localparam logic [UNBAL_W-1:0]   UNBALANCE_RST   = 8'd3;

	// per-lane decision flags, valid in the second stage
	typedef struct packed {
		logic over;   // at or above overvoltage
		logic start;  // at or above minimum plus offset
		logic hold;   // strictly above minimum
	} lane_dec_t;

	// item-wide controls found by the merge stage
	typedef struct packed {
		logic              incoherent;
		logic              fresh;
		logic [SLOT_W-1:0] slots;
	} merge_ctl_t;

	// five slots below 30 C, one fewer per further 10 C, none from 70 C
	function automatic logic [SLOT_W-1:0] slot_limit(input logic signed [TEMP_W-1:0] temp);
		logic [SLOT_W-1:0] lim;
		logic              found;
		lim   = '0;
		found = 1'b0;
		for (int i = 0; i < MAX_CELLS; i++) begin
			if (!found && (int'(temp) < TEMP_BASE_C + i * TEMP_STEP_C)) begin
				lim   = SLOT_W'(MAX_CELLS - i);
				found = 1'b1;
			end
		end
		return lim;
	endfunction

endpackage

>>> rtl/core/cbs_lane.sv
module cbs_lane
	import cbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 load,
	input  logic [CELL_MV_W-1:0] cell_mv,
	input  logic [CELL_MV_W-1:0] valid_low_mv,
	input  logic [CELL_MV_W-1:0] valid_high_mv,
	input  logic [CELL_MV_W-1:0] overvoltage_mv,
	input  logic [UNBAL_W-1:0]   unbalance_mv,
	input  logic [CELL_MV_W-1:0] vmin_s1,
	output logic                 in_window,
	output lane_dec_t            dec
);

	logic [CELL_MV_W-1:0] cell_s1;
	logic [CELL_MV_W:0]   start_lvl;

	// first stage: window screen on the raw reading
	assign in_window = (cell_mv >= valid_low_mv) && (cell_mv <= valid_high_mv);

	always_ff @(posedge clk) begin
		if (load) begin
			cell_s1 <= cell_mv;
		end
	end

	// second stage: compare against the merged minimum, no wrap on the sum
	assign start_lvl = {1'b0, vmin_s1} + {{(CELL_MV_W + 1 - UNBAL_W){1'b0}}, unbalance_mv};

	always_comb begin
		dec.over  = cell_s1 >= overvoltage_mv;
		dec.start = {1'b0, cell_s1} >= start_lvl;
		dec.hold  = cell_s1 > vmin_s1;
	end

endmodule

>>> rtl/core/cbs_merge.sv
module cbs_merge
	import cbs_pkg::*;
#(
	parameter int CELL_COUNT = CELL_COUNT_DEF
) (
	input  logic                                  clk,
	input  logic                                  load,
	input  logic [CELL_COUNT-1:0][CELL_MV_W-1:0]  cells_mv,
	input  logic [CELL_COUNT-1:0]                 in_window,
	input  logic signed [TEMP_W-1:0]              temperature_c,
	input  logic                                  reading_fresh,
	input  logic [CELL_MV_W-1:0]                  min_start_mv,
	output logic [CELL_MV_W-1:0]                  vmin_s1,
	output merge_ctl_t                            ctl_s1
);

	logic [CELL_MV_W-1:0] vmin;
	merge_ctl_t           ctl;

	// short chain over at most five lanes
	always_comb begin
		vmin = min_start_mv;
		for (int i = 0; i < CELL_COUNT; i++) begin
			if (in_window[i] && (cells_mv[i] < vmin)) begin
				vmin = cells_mv[i];
			end
		end
		ctl.incoherent = ~&in_window;
		ctl.fresh      = reading_fresh;
		ctl.slots      = slot_limit(temperature_c);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vmin_s1 <= vmin;
			ctl_s1  <= ctl;
		end
	end

endmodule

>>> rtl/core/cbs_select.sv
module cbs_select
	import cbs_pkg::*;
#(
	parameter int CELL_COUNT = CELL_COUNT_DEF
) (
	input  lane_dec_t [CELL_COUNT-1:0] dec,
	input  merge_ctl_t                 ctl,
	input  logic                       balance_enable,
	input  logic [CELL_COUNT-1:0]      prev_mask,
	output logic [CELL_COUNT-1:0]      next_mask
);

	logic [SLOT_W-1:0]     slots;
	logic [CELL_COUNT-1:0] grant;
	logic                  want;

	// lower index takes a slot first
	always_comb begin
		slots = ctl.slots;
		grant = '0;
		for (int i = 0; i < CELL_COUNT; i++) begin
			if (slots == '0) begin
				want = 1'b0;
			end else if (dec[i].over) begin
				want = 1'b1;
			end else if (!prev_mask[i]) begin
				want = dec[i].start;
			end else begin
				want = dec[i].hold;
			end
			if (want) begin
				grant[i] = 1'b1;
				slots    = slots - 1'b1;
			end
		end

		if (ctl.incoherent || !balance_enable) begin
			next_mask = '0;
		end else if (!ctl.fresh) begin
			next_mask = prev_mask;
		end else begin
			next_mask = grant;
		end
	end

endmodule

>>> rtl/core/cell_balance_selector.sv
// Path: an accepted input passes the stage-1 registers, then the output register.
// Throughput: one transaction per cycle unless m_tready holds the output; the
// balancing mask is the only state carried between items, resolved in the second stage.
// Reset (arst_n low, asynchronous): pipeline empty, mask cleared, registers
// back to enable 0, 4200, 4200, 2500, 4500, 3 mV.
module cell_balance_selector
	import cbs_pkg::*;
#(
	parameter int CELL_COUNT = CELL_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // cell0_mv, cell1_mv, cell2_mv, cell3_mv,
	                                          // cell4_mv, temperature_c
	input  logic                   s_tuser,   // reading_fresh
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // balance_mask[4:0], mask_changed,
	                                          // readings_incoherent, zero pad
	// configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic                 balance_enable_q;
	logic [CELL_MV_W-1:0] overvoltage_mv_q;
	logic [CELL_MV_W-1:0] min_start_mv_q;
	logic [CELL_MV_W-1:0] valid_low_mv_q;
	logic [CELL_MV_W-1:0] valid_high_mv_q;
	logic [UNBAL_W-1:0]   unbalance_mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balance_enable_q <= 1'b0;
			overvoltage_mv_q <= OVERVOLTAGE_RST;
			min_start_mv_q   <= MIN_START_RST;
			valid_low_mv_q   <= VALID_LOW_RST;
			valid_high_mv_q  <= VALID_HIGH_RST;
			unbalance_mv_q   <= UNBALANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BALANCE_ENABLE: balance_enable_q <= cfg_data[0];
				REG_OVERVOLTAGE:    overvoltage_mv_q <= cfg_data;
				REG_MIN_START:      min_start_mv_q   <= cfg_data;
				REG_VALID_LOW:      valid_low_mv_q   <= cfg_data;
				REG_VALID_HIGH:     valid_high_mv_q  <= cfg_data;
				REG_UNBALANCE:      unbalance_mv_q   <= cfg_data[UNBAL_W-1:0];
				default: ;  // unused index, write dropped
			endcase
		end
	end

	// handshake: stage 1 feeds the output register, which may hold a result
	// while stage 1 already takes the next transaction
	logic s1_valid_q;
	logic out_valid_q;
	logic adv2;
	logic accept;

	assign adv2     = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv2;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv2) begin
				s1_valid_q <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// unpack the used cells
	logic [CELL_COUNT-1:0][CELL_MV_W-1:0] cells_mv;
	logic signed [TEMP_W-1:0]             temperature_c;

	always_comb begin
		for (int i = 0; i < CELL_COUNT; i++) begin
			cells_mv[i] = s_tdata[i*CELL_MV_W +: CELL_MV_W];
		end
	end
	assign temperature_c = s_tdata[TEMP_LSB +: TEMP_W];

	// one lane per used cell
	logic [CELL_COUNT-1:0]     in_window;
	lane_dec_t [CELL_COUNT-1:0] dec;
	logic [CELL_MV_W-1:0]      vmin_s1;
	merge_ctl_t                ctl_s1;

	for (genvar g = 0; g < CELL_COUNT; g++) begin : g_lane
		cbs_lane u_lane (
			.clk            (clk),
			.load           (accept),
			.cell_mv        (cells_mv[g]),
			.valid_low_mv   (valid_low_mv_q),
			.valid_high_mv  (valid_high_mv_q),
			.overvoltage_mv (overvoltage_mv_q),
			.unbalance_mv   (unbalance_mv_q),
			.vmin_s1        (vmin_s1),
			.in_window      (in_window[g]),
			.dec            (dec[g])
		);
	end

	// minimum, coherence and temperature slot limit across lanes
	cbs_merge #(
		.CELL_COUNT (CELL_COUNT)
	) u_merge (
		.clk           (clk),
		.load          (accept),
		.cells_mv      (cells_mv),
		.in_window     (in_window),
		.temperature_c (temperature_c),
		.reading_fresh (s_tuser),
		.min_start_mv  (min_start_mv_q),
		.vmin_s1       (vmin_s1),
		.ctl_s1        (ctl_s1)
	);

	// second stage: slot allocation against the held mask
	logic [CELL_COUNT-1:0] mask_q;
	logic [CELL_COUNT-1:0] next_mask;

	cbs_select #(
		.CELL_COUNT (CELL_COUNT)
	) u_select (
		.dec            (dec),
		.ctl            (ctl_s1),
		.balance_enable (balance_enable_q),
		.prev_mask      (mask_q),
		.next_mask      (next_mask)
	);

	// mask state advances only when a result moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (adv2) begin
			mask_q <= next_mask;
		end
	end

	logic [MAX_CELLS-1:0] out_mask_q;
	logic                 out_changed_q;
	logic                 out_incoherent_q;

	always_ff @(posedge clk) begin
		if (adv2) begin
			out_mask_q       <= MAX_CELLS'(next_mask);
			out_changed_q    <= next_mask != mask_q;
			out_incoherent_q <= ctl_s1.incoherent;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - MAX_CELLS - 2){1'b0}},
	                   out_incoherent_q, out_changed_q, out_mask_q};

endmodule
